@@ hw/rtl/rvrt_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, constants and arctangent table for the vertex rotate/translate block.
package rvrt_pkg;

	localparam int COORD_W   = 32;
	localparam int ANGLE_W   = 16;
	localparam int TABLE_LEN = 24;
	localparam int CX_W      = 34;  // cordic x/y, signed Q2.30 with headroom
	localparam int CZ_W      = 33;  // cordic residual angle, 2^32 per turn

	localparam logic signed [CX_W-1:0] GAIN_Q30 = 34'sh0_26DD_3B6A;

	// rounded atan(2^-i), 2^32 per turn
	function automatic logic [31:0] atan_q32(input int unsigned idx);
		logic [31:0] v;
		case (idx)
			0:       v = 32'h2000_0000;
			1:       v = 32'h12E4_051E;
			2:       v = 32'h09FB_385B;
			3:       v = 32'h0511_11D4;
			4:       v = 32'h028B_0D43;
			5:       v = 32'h0145_D7E1;
			6:       v = 32'h00A2_F61E;
			7:       v = 32'h0051_7C55;
			8:       v = 32'h0028_BE53;
			9:       v = 32'h0014_5F2F;
			10:      v = 32'h000A_2F98;
			11:      v = 32'h0005_17CC;
			12:      v = 32'h0002_8BE6;
			13:      v = 32'h0001_45F3;
			14:      v = 32'h0000_A2FA;
			15:      v = 32'h0000_517D;
			16:      v = 32'h0000_28BE;
			17:      v = 32'h0000_145F;
			18:      v = 32'h0000_0A30;
			19:      v = 32'h0000_0518;
			20:      v = 32'h0000_028C;
			21:      v = 32'h0000_0146;
			22:      v = 32'h0000_00A3;
			23:      v = 32'h0000_0051;
			default: v = 32'h0000_0000;
		endcase
		return v;
	endfunction

endpackage

@@ hw/rtl/rigid_vertex_rotate_translate.sv @@
`timescale 1ns / 1ps
// Top level: rotate a body-space vertex by a binary angle and add the body position.
//
// Use: drive turn_angle, local_x/y, body_x/y and last_vertex with start high;
// the transfer happens on any clock edge with start high and busy low. busy
// stays low, so a new vertex may enter on every cycle.
// Each vertex yields one result: done pulses for exactly one cycle with
// world_x, world_y (Q16.16, saturated) and last_out on the result ports.
// The pipeline is one reduction stage, one register per CORDIC rotation,
// a rounding/quadrant stage, the multiply stage, the rounding sum stage
// and the translate/saturate stage.
// Throughput is one vertex per cycle; the CORDIC chain sets the latency.
// Results come out in input order. The receiver cannot stall the pipe and
// must take each result in its cycle.
// Reset clears all valid bits; items in flight are dropped and done stays
// low until new vertices have gone through.
module rigid_vertex_rotate_translate #(
	parameter int CORDIC_STAGES = 16,
	parameter int FRAC_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        turn_angle,
	input  logic signed [31:0] local_x,
	input  logic signed [31:0] local_y,
	input  logic signed [31:0] body_x,
	input  logic signed [31:0] body_y,
	input  logic               last_vertex,
	output logic               done,
	output logic signed [31:0] world_x,
	output logic signed [31:0] world_y,
	output logic               last_out
);

	localparam int NS  = (CORDIC_STAGES < rvrt_pkg::TABLE_LEN) ?
		CORDIC_STAGES : rvrt_pkg::TABLE_LEN;
	localparam int CL  = NS + 2;
	localparam int LAT = NS + 5;
	localparam int CW  = FRAC_BITS + 2;
	localparam int PW  = rvrt_pkg::COORD_W + CW;
	localparam int RW  = PW + 1 - FRAC_BITS;
	localparam int SW  = RW + 1;
	localparam logic signed [PW:0] HALF = (PW + 1)'(1) << (FRAC_BITS - 1);

	function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
		logic signed [31:0] r;
		if (v[SW-1:31] == {(SW - 31){v[SW-1]}}) begin
			r = v[31:0];
		end else if (v[SW-1]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// sine/cosine
	logic                 cs_vld;
	logic signed [CW-1:0] cos_v, sin_v;

	rvrt_cordic #(
		.CORDIC_STAGES(CORDIC_STAGES),
		.FRAC_BITS    (FRAC_BITS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (accept),
		.angle  (turn_angle),
		.out_vld(cs_vld),
		.cos_v  (cos_v),
		.sin_v  (sin_v)
	);

	// payload delay matching the cordic latency
	logic signed [31:0] lx_q [CL];
	logic signed [31:0] ly_q [CL];
	logic signed [31:0] bx_q [CL];
	logic signed [31:0] by_q [CL];
	logic               lst_q [CL];

	always_ff @(posedge clk) begin
		lx_q[0]  <= local_x;
		ly_q[0]  <= local_y;
		bx_q[0]  <= body_x;
		by_q[0]  <= body_y;
		lst_q[0] <= last_vertex;
		for (int k = 1; k < CL; k++) begin
			lx_q[k]  <= lx_q[k-1];
			ly_q[k]  <= ly_q[k-1];
			bx_q[k]  <= bx_q[k-1];
			by_q[k]  <= by_q[k-1];
			lst_q[k] <= lst_q[k-1];
		end
	end

	// s4: products
	logic                 vld_s4;
	logic signed [PW-1:0] p_xc_s4, p_ys_s4, p_xs_s4, p_yc_s4;
	logic signed [31:0]   bx_s4, by_s4;
	logic                 lst_s4;

	// s5: rotated, rounded to Q16.16 scale with extra integer bits
	logic                 vld_s5;
	logic signed [RW-1:0] rx_s5, ry_s5;
	logic signed [31:0]   bx_s5, by_s5;
	logic                 lst_s5;

	// s6: translated and saturated
	logic                 vld_s6;
	logic signed [31:0]   wx_s6, wy_s6;
	logic                 lst_s6;

	logic signed [PW:0]   sum_x, sum_y;
	logic signed [SW-1:0] tx, ty;

	assign sum_x = (PW + 1)'(p_xc_s4) - (PW + 1)'(p_ys_s4) + HALF;
	assign sum_y = (PW + 1)'(p_xs_s4) + (PW + 1)'(p_yc_s4) + HALF;
	assign tx    = SW'(rx_s5) + SW'(bx_s5);
	assign ty    = SW'(ry_s5) + SW'(by_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s4 <= cs_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		p_xc_s4 <= PW'(lx_q[CL-1]) * PW'(cos_v);
		p_ys_s4 <= PW'(ly_q[CL-1]) * PW'(sin_v);
		p_xs_s4 <= PW'(lx_q[CL-1]) * PW'(sin_v);
		p_yc_s4 <= PW'(ly_q[CL-1]) * PW'(cos_v);
		bx_s4   <= bx_q[CL-1];
		by_s4   <= by_q[CL-1];
		lst_s4  <= lst_q[CL-1];

		rx_s5  <= sum_x[PW:FRAC_BITS];
		ry_s5  <= sum_y[PW:FRAC_BITS];
		bx_s5  <= bx_s4;
		by_s5  <= by_s4;
		lst_s5 <= lst_s4;

		wx_s6  <= sat32(tx);
		wy_s6  <= sat32(ty);
		lst_s6 <= lst_s5;
	end

	assign done     = vld_s6;
	assign world_x  = wx_s6;
	assign world_y  = wy_s6;
	assign last_out = lst_s6;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("transfer did not produce a result after the pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result strobe without a matching input transfer");

	a_last_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (last_out == $past(last_vertex, LAT)))
		else $error("last-vertex mark out of step with its result");

endmodule

@@ hw/rtl/rvrt_cordic.sv @@
`timescale 1ns / 1ps
// Pipelined CORDIC sine/cosine with quadrant reduction, one rotation per stage.
module rvrt_cordic #(
	parameter int CORDIC_STAGES = 16,
	parameter int FRAC_BITS     = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_vld,
	input  logic [rvrt_pkg::ANGLE_W-1:0]         angle,
	output logic                                 out_vld,
	output logic signed [FRAC_BITS+1:0]          cos_v,
	output logic signed [FRAC_BITS+1:0]          sin_v
);

	localparam int NS = (CORDIC_STAGES < rvrt_pkg::TABLE_LEN) ?
		CORDIC_STAGES : rvrt_pkg::TABLE_LEN;
	localparam int SH   = 30 - FRAC_BITS;
	localparam int CW   = FRAC_BITS + 2;
	localparam int CX_W = rvrt_pkg::CX_W;
	localparam int CZ_W = rvrt_pkg::CZ_W;
	localparam logic signed [CX_W-1:0] RND = CX_W'(1) << (SH - 1);

	typedef enum logic [1:0] {QD_0, QD_90, QD_180, QD_270} quad_t;

	// quadrant reduction
	logic [15:0] ang_bias;
	logic [15:0] resid;
	assign ang_bias = angle + 16'h2000;
	assign resid    = angle - {ang_bias[15:14], 14'd0};

	logic                   vld_s1;
	logic signed [CZ_W-1:0] z_s1;
	quad_t                  q_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		z_s1 <= {resid[15], resid, 16'd0};
		q_s1 <= quad_t'(ang_bias[15:14]);
	end

	// rotation stages
	logic                   vld_s2 [NS];
	logic signed [CX_W-1:0] x_s2   [NS];
	logic signed [CX_W-1:0] y_s2   [NS];
	logic signed [CZ_W-1:0] z_s2   [NS];
	quad_t                  q_s2   [NS];

	for (genvar i = 0; i < NS; i++) begin : g_rot
		logic                   vi;
		logic signed [CX_W-1:0] xi;
		logic signed [CX_W-1:0] yi;
		logic signed [CZ_W-1:0] zi;
		logic signed [CZ_W-1:0] ai;
		quad_t                  qi;

		if (i == 0) begin : g_first
			assign vi = vld_s1;
			assign xi = rvrt_pkg::GAIN_Q30;
			assign yi = '0;
			assign zi = z_s1;
			assign qi = q_s1;
		end else begin : g_next
			assign vi = vld_s2[i-1];
			assign xi = x_s2[i-1];
			assign yi = y_s2[i-1];
			assign zi = z_s2[i-1];
			assign qi = q_s2[i-1];
		end

		assign ai = $signed({1'b0, rvrt_pkg::atan_q32(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[i] <= 1'b0;
			end else begin
				vld_s2[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (!zi[CZ_W-1]) begin
				x_s2[i] <= xi - (yi >>> i);
				y_s2[i] <= yi + (xi >>> i);
				z_s2[i] <= zi - ai;
			end else begin
				x_s2[i] <= xi + (yi >>> i);
				y_s2[i] <= yi - (xi >>> i);
				z_s2[i] <= zi + ai;
			end
			q_s2[i] <= qi;
		end
	end

	// round to FRAC_BITS and undo quadrant
	logic signed [CX_W-1:0] rnd_x, rnd_y;
	logic signed [CW-1:0]   rc, rs;
	logic signed [CW-1:0]   cos_d, sin_d;

	assign rnd_x = x_s2[NS-1] + RND;
	assign rnd_y = y_s2[NS-1] + RND;
	assign rc    = rnd_x[SH +: CW];
	assign rs    = rnd_y[SH +: CW];

	always_comb begin
		case (q_s2[NS-1])
			QD_0:    begin cos_d = rc;  sin_d = rs;  end
			QD_90:   begin cos_d = -rs; sin_d = rc;  end
			QD_180:  begin cos_d = -rc; sin_d = -rs; end
			QD_270:  begin cos_d = rs;  sin_d = -rc; end
			default: begin cos_d = rc;  sin_d = rs;  end
		endcase
	end

	logic                 vld_s3;
	logic signed [CW-1:0] cos_s3, sin_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		cos_s3 <= cos_d;
		sin_s3 <= sin_d;
	end

	assign out_vld = vld_s3;
	assign cos_v   = cos_s3;
	assign sin_v   = sin_s3;

endmodule
